// ===== rtl/core/bth_pkg.sv =====
package bth_pkg;

  // heap geometry
  localparam int HEAP_WORDS = 16384;
  localparam int IW = $clog2(HEAP_WORDS);   // header memory index width
  localparam int SW = IW + 1;               // word count incl. whole heap

  // operation codes
  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_SHRINK  = 3'd2;
  localparam logic [2:0] OP_FREE_TY = 3'd3;
  localparam logic [2:0] OP_STREAM  = 3'd4;
  localparam logic [2:0] OP_DONE    = 3'd5;
  localparam logic [2:0] OP_QUERY   = 3'd6;
  localparam logic [2:0] OP_RSVD    = 3'd7;

  // error codes
  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_NOSP16 = 2'd1;
  localparam logic [1:0] ERR_NOSP   = 2'd2;
  localparam logic [1:0] ERR_BAD    = 2'd3;

  // block status
  localparam logic [1:0] ST_FREE   = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_STREAM = 2'd2;

  localparam logic [7:0] SOFT_FAIL_TYPE = 8'd16;
  localparam int HDR_WORDS = 2;
  localparam int HDR_BYTES = 8;
  localparam int ROUND_ADD = 11;

  // block header as held in memory
  typedef struct packed {
    logic [1:0]    status;
    logic [7:0]    mtype;
    logic [SW-1:0] size;
  } hdr_t;

  function automatic logic is_reloc(input logic [7:0] t);
    return (t == 8'd1) || (t == 8'd2) || (t == 8'd4) || (t == 8'd44) || (t == 8'd47);
  endfunction

endpackage

// ===== rtl/core/bth_in_if.sv =====
interface bth_in_if import bth_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [15:0] alloc_bytes;
  logic [7:0]  mem_type;
  logic [15:0] block_address;
  logic [15:0] shrink_bytes;

  modport source (output valid, operation, alloc_bytes, mem_type, block_address,
                  shrink_bytes, input ready);
  modport sink (input valid, operation, alloc_bytes, mem_type, block_address,
                shrink_bytes, output ready);
endinterface

// ===== rtl/core/bth_out_if.sv =====
interface bth_out_if import bth_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] payload_address;
  logic [1:0]  error_code;
  logic        block_valid;
  logic [15:0] payload_bytes;
  logic [16:0] free_bytes;
  logic [13:0] freed_count;

  modport source (output valid, payload_address, error_code, block_valid,
                  payload_bytes, free_bytes, freed_count, input ready);
  modport sink (input valid, payload_address, error_code, block_valid,
                payload_bytes, free_bytes, freed_count, output ready);
endinterface

// ===== rtl/core/boundary_tag_heap_allocator_top.sv =====
// channel   | dir | word
// in_chan   | in  | operation, alloc_bytes, mem_type, block_address, shrink_bytes
// out_chan  | out | payload_address, error_code, block_valid, payload_bytes,
//           |     | free_bytes, freed_count
//
// One request at a time. A request walks the header chain from word 0, one
// header per cycle through the single header memory (registered read). After
// the walk come the operation step, up to two writes and the result step, and
// free by type adds a release step per block released. Reset needs no clearing
// pass: a flag makes header 0 read as one free block of the whole heap until
// first written.
// A result waits in the output register while the next word is taken.
module boundary_tag_heap_allocator_top import bth_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  bth_in_if.sink    in_chan,
  bth_out_if.source out_chan
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AWALK = 4'd1;
  localparam logic [3:0] S_AFIN  = 4'd2;
  localparam logic [3:0] S_LWALK = 4'd3;
  localparam logic [3:0] S_LOP   = 4'd4;
  localparam logic [3:0] S_TWALK = 4'd5;
  localparam logic [3:0] S_RELN  = 4'd6;
  localparam logic [3:0] S_SHN   = 4'd7;
  localparam logic [3:0] S_WR2   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  localparam logic [SW:0]   HEAP_W = (SW+1)'(HEAP_WORDS);
  localparam logic [SW-1:0] HEAP_S = SW'(HEAP_WORDS);

  // header memory
  hdr_t          mem [HEAP_WORDS];
  hdr_t          rdata_r;
  logic          rd_init_r;
  logic          init0_r;
  logic          rd_en, we;
  logic [IW-1:0] rd_addr, waddr;
  hdr_t          wdata;
  hdr_t          hd;

  // request state
  logic [3:0]    state_r;
  logic [2:0]    op_r;
  logic [7:0]    type_r;
  logic [15:0]   sbytes_r;
  logic [IW-1:0] hw_r;
  logic [SW-1:0] h_r, prev_r, best_r, bsize_r, w_r, used_r;
  hdr_t          cur_r, prevhdr_r;
  logic          have_r, found_r, nx_ok_r, rel_walk_r;
  logic [IW-1:0] wq_addr_r;
  hdr_t          wq_data_r;

  // result working and output registers
  logic [15:0] pay_r, pb_r;
  logic [1:0]  err_r;
  logic        val_r;
  logic [13:0] freed_r;
  logic        out_valid_r;
  logic [15:0] o_pay_r, o_pb_r;
  logic [1:0]  o_err_r;
  logic        o_val_r;
  logic [16:0] o_free_r;
  logic [13:0] o_freed_r;

  // shared datapath
  logic          in_acc, reloc, fit, pmerge, nfree;
  logic [SW:0]   nxt_h, cur_nx, res_nx;
  logic [SW-1:0] merged, res_h, res_size, wf, used_sub;
  logic [IW-1:0] w14;
  logic          sh_bad, sh_small;
  logic [SW-1:0] alloc_w;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign hd       = rd_init_r ? hdr_t'{ST_FREE, 8'd0, HEAP_S} : rdata_r;
  assign reloc    = is_reloc(type_r);
  assign fit      = (hd.status == ST_FREE) && (hd.size >= w_r);
  assign nxt_h    = {1'b0, h_r} + {1'b0, hd.size};
  assign cur_nx   = {1'b0, h_r} + {1'b0, cur_r.size};
  assign nfree    = nx_ok_r && (hd.status == ST_FREE);
  assign merged   = cur_r.size + (nfree ? hd.size : '0);
  assign pmerge   = have_r && (prevhdr_r.status == ST_FREE);
  assign res_h    = pmerge ? prev_r : h_r;
  assign res_size = pmerge ? prevhdr_r.size + merged : merged;
  assign res_nx   = {1'b0, res_h} + {1'b0, res_size};
  assign used_sub = (used_r >= cur_r.size) ? used_r - cur_r.size : '0;
  assign wf       = ((bsize_r - w_r) < SW'(HDR_WORDS)) ? bsize_r : w_r;
  assign w14      = sbytes_r[15:2];
  assign sh_small = sbytes_r[15:2] < 14'(HDR_BYTES / 4);
  assign sh_bad   = ({2'b00, w14} + (IW+2)'(HDR_WORDS)) > {1'b0, cur_r.size};
  assign alloc_w  = SW'((17'(in_chan.alloc_bytes) + 17'(ROUND_ADD)) >> 2);

  assign in_chan.ready = (state_r == S_IDLE);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    unique case (state_r)
      S_IDLE: rd_en = in_acc;
      S_AWALK: begin
        rd_addr = nxt_h[IW-1:0];
        rd_en   = (hd.size != '0) && !(fit && reloc) && (nxt_h < HEAP_W);
      end
      S_AFIN: begin
        we = 1'b1;
        if (wf == bsize_r) begin
          waddr = best_r[IW-1:0];
          wdata = hdr_t'{ST_DONE, type_r, wf};
        end else if (reloc) begin
          waddr = IW'(best_r + wf);
          wdata = hdr_t'{ST_FREE, 8'd0, bsize_r - wf};
        end else begin
          waddr = best_r[IW-1:0];
          wdata = hdr_t'{ST_FREE, 8'd0, bsize_r - wf};
        end
      end
      S_LWALK: begin
        rd_addr = nxt_h[IW-1:0];
        rd_en   = (h_r != {1'b0, hw_r}) && (hd.size != '0) && (nxt_h < HEAP_W)
                  && (nxt_h <= {2'b00, hw_r});
      end
      S_LOP: begin
        rd_addr = cur_nx[IW-1:0];
        if (op_r == OP_QUERY) begin
          rd_en = 1'b0;
        end else if (cur_r.status == ST_FREE) begin
          rd_en = 1'b0;
        end else if (op_r == OP_STREAM || op_r == OP_DONE) begin
          we    = 1'b1;
          waddr = h_r[IW-1:0];
          wdata = hdr_t'{(op_r == OP_STREAM) ? ST_STREAM : ST_DONE, cur_r.mtype,
                         cur_r.size};
        end else if (op_r == OP_FREE) begin
          rd_en = cur_nx < HEAP_W;
        end else begin
          rd_en = !sh_small && !sh_bad && (cur_nx < HEAP_W);
        end
      end
      S_TWALK: begin
        if (hd.status == ST_DONE && hd.mtype == type_r) begin
          rd_addr = nxt_h[IW-1:0];
        end else begin
          rd_addr = nxt_h[IW-1:0];
        end
        rd_en = (hd.size != '0) && (nxt_h < HEAP_W);
      end
      S_RELN: begin
        we      = 1'b1;
        waddr   = res_h[IW-1:0];
        wdata   = pmerge ? hdr_t'{prevhdr_r.status, prevhdr_r.mtype, res_size}
                         : hdr_t'{ST_FREE, 8'd0, merged};
        rd_addr = res_nx[IW-1:0];
        rd_en   = rel_walk_r && (res_nx < HEAP_W);
      end
      S_SHN: begin
        we    = 1'b1;
        waddr = h_r[IW-1:0];
        wdata = hdr_t'{cur_r.status, cur_r.mtype, cur_r.size - SW'(w14)};
      end
      S_WR2: begin
        we    = 1'b1;
        waddr = wq_addr_r;
        wdata = wq_data_r;
      end
      default: ;
    endcase
  end

  // header memory, one read and one write a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_init_r <= 1'b0;
      init0_r   <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_init_r <= (rd_addr == '0) && !init0_r && !(we && waddr == '0);
      end
      if (we && waddr == '0) begin
        init0_r <= 1'b1;
      end
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the result step reloads the output register itself
      if (out_valid_r && out_chan.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r      <= in_chan.operation;
            type_r    <= in_chan.mem_type;
            sbytes_r  <= in_chan.shrink_bytes;
            hw_r      <= in_chan.block_address[15:2] - 14'(HDR_BYTES / 4);
            w_r       <= alloc_w;
            h_r       <= '0;
            have_r    <= 1'b0;
            found_r   <= 1'b0;
            pay_r     <= '0;
            pb_r      <= '0;
            err_r     <= ERR_OK;
            val_r     <= 1'b0;
            freed_r   <= '0;
            priority case (1'b1)
              in_chan.operation == OP_ALLOC:   state_r <= S_AWALK;
              in_chan.operation == OP_FREE_TY: state_r <= S_TWALK;
              in_chan.operation == OP_RSVD: begin
                err_r   <= ERR_BAD;
                state_r <= S_FIN;
              end
              (in_chan.block_address < 16'(HDR_BYTES))
                || (in_chan.block_address[1:0] != 2'b00): begin
                err_r   <= ERR_BAD;
                state_r <= S_FIN;
              end
              default: state_r <= S_LWALK;
            endcase
          end
        end
        // first / last fit search
        S_AWALK: begin
          if (fit) begin
            best_r  <= h_r;
            bsize_r <= hd.size;
            found_r <= 1'b1;
          end
          if (hd.size != '0 && !(fit && reloc) && nxt_h < HEAP_W) begin
            h_r <= nxt_h[SW-1:0];
          end else if (found_r || fit) begin
            state_r <= S_AFIN;
          end else begin
            err_r   <= (type_r == SOFT_FAIL_TYPE) ? ERR_NOSP16 : ERR_NOSP;
            state_r <= S_FIN;
          end
        end
        S_AFIN: begin
          used_r <= used_r + wf;
          if (wf == bsize_r) begin
            pay_r   <= {best_r[IW-1:0], 2'b00} + 16'(HDR_BYTES);
            state_r <= S_FIN;
          end else if (reloc) begin
            pay_r     <= {best_r[IW-1:0], 2'b00} + 16'(HDR_BYTES);
            wq_addr_r <= best_r[IW-1:0];
            wq_data_r <= hdr_t'{ST_DONE, type_r, wf};
            state_r   <= S_WR2;
          end else begin
            pay_r     <= {IW'(best_r + bsize_r - wf), 2'b00} + 16'(HDR_BYTES);
            wq_addr_r <= IW'(best_r + bsize_r - wf);
            wq_data_r <= hdr_t'{ST_DONE, type_r, wf};
            state_r   <= S_WR2;
          end
        end
        // find the block whose header sits at hw
        S_LWALK: begin
          if (h_r == {1'b0, hw_r}) begin
            cur_r   <= hd;
            state_r <= S_LOP;
          end else if (hd.size == '0 || nxt_h >= HEAP_W || nxt_h > {2'b00, hw_r}) begin
            err_r   <= ERR_BAD;
            state_r <= S_FIN;
          end else begin
            prev_r    <= h_r;
            prevhdr_r <= hd;
            have_r    <= 1'b1;
            h_r       <= nxt_h[SW-1:0];
          end
        end
        S_LOP: begin
          nx_ok_r    <= cur_nx < HEAP_W;
          rel_walk_r <= 1'b0;
          if (op_r == OP_QUERY) begin
            val_r   <= cur_r.status == ST_DONE;
            pb_r    <= {cur_r.size[IW-1:0], 2'b00} - 16'(HDR_BYTES);
            state_r <= S_FIN;
          end else if (cur_r.status == ST_FREE) begin
            err_r   <= ERR_BAD;
            state_r <= S_FIN;
          end else if (op_r == OP_FREE) begin
            state_r <= S_RELN;
          end else if (op_r == OP_SHRINK) begin
            if (sh_small) begin
              state_r <= S_FIN;
            end else if (sh_bad) begin
              err_r   <= ERR_BAD;
              state_r <= S_FIN;
            end else begin
              state_r <= S_SHN;
            end
          end else begin
            state_r <= S_FIN;
          end
        end
        // free by type walk
        S_TWALK: begin
          if (hd.size == '0) begin
            state_r <= S_FIN;
          end else if (hd.status == ST_DONE && hd.mtype == type_r) begin
            cur_r      <= hd;
            nx_ok_r    <= nxt_h < HEAP_W;
            rel_walk_r <= 1'b1;
            state_r    <= S_RELN;
          end else begin
            prev_r    <= h_r;
            prevhdr_r <= hd;
            have_r    <= 1'b1;
            if (nxt_h < HEAP_W) begin
              h_r <= nxt_h[SW-1:0];
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        // release with merge on both sides
        S_RELN: begin
          used_r <= used_sub;
          if (rel_walk_r) begin
            freed_r   <= freed_r + 14'd1;
            prev_r    <= res_h;
            prevhdr_r <= pmerge ? hdr_t'{prevhdr_r.status, prevhdr_r.mtype, res_size}
                                : hdr_t'{ST_FREE, 8'd0, merged};
            have_r    <= 1'b1;
            if (res_nx < HEAP_W) begin
              h_r     <= res_nx[SW-1:0];
              state_r <= S_TWALK;
            end else begin
              state_r <= S_FIN;
            end
          end else begin
            state_r <= S_FIN;
          end
        end
        // shrink: tail becomes free, merged with a free successor
        S_SHN: begin
          used_r    <= (used_r >= SW'(w14)) ? used_r - SW'(w14) : '0;
          wq_addr_r <= IW'(h_r + cur_r.size - SW'(w14));
          wq_data_r <= hdr_t'{ST_FREE, 8'd0, SW'(w14) + (nfree ? hd.size : '0)};
          state_r   <= S_WR2;
        end
        S_WR2: state_r <= S_FIN;
        S_FIN: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            o_pay_r     <= pay_r;
            o_err_r     <= err_r;
            o_val_r     <= val_r;
            o_pb_r      <= pb_r;
            o_free_r    <= {HEAP_S - used_r, 2'b00};
            o_freed_r   <= freed_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.payload_address = o_pay_r;
  assign out_chan.error_code      = o_err_r;
  assign out_chan.block_valid     = o_val_r;
  assign out_chan.payload_bytes   = o_pb_r;
  assign out_chan.free_bytes      = o_free_r;
  assign out_chan.freed_count     = o_freed_r;

endmodule
